// ===== rtl/arp_cache_table_macros.svh =====
// Assertion macros shared by the ARP cache table modules.
`ifndef ARP_CACHE_TABLE_MACROS_SVH
`define ARP_CACHE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ARPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arp cache table: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ARPC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arp cache table: next-cycle check failed");

`endif

// ===== rtl/arpc_pkg.sv =====
// Types and constants of the ARP cache table.
package arpc_pkg;

  localparam int ARPC_ENTRIES = 16;
  localparam int IP_BYTES     = 4;
  localparam int MAC_BYTES    = 6;
  localparam int IP_W         = IP_BYTES * 8;
  localparam int MAC_W        = MAC_BYTES * 8;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arpc_entry_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             table_full;
  } arpc_res_t;

endpackage

// ===== rtl/arpc_req_if.sv =====
// Request and response channel interfaces of the ARP cache table.
interface arpc_req_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [IP_W-1:0]  ip_addr;
  logic [MAC_W-1:0] mac_addr;

  modport source (output valid, output kind, output ip_addr, output mac_addr, input ready);
  modport sink   (input valid, input kind, input ip_addr, input mac_addr, output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] found_mac;
  logic             table_full;

  modport source (output valid, output hit, output found_mac, output table_full, input ready);
  modport sink   (input valid, input hit, input found_mac, input table_full, output ready);
endinterface

// ===== rtl/arpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/arpc_ctrl.sv =====
// Search and update sequencer of the ARP cache table, with its entry memory.
`include "arp_cache_table_macros.svh"

module arpc_ctrl import arpc_pkg::*; #(
  parameter int ENTRIES = ARPC_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  arpc_req_if.sink   req,
  output logic       res_valid,
  input  logic       res_ready,
  output arpc_res_t  res
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = $bits(arpc_entry_t);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESP   = 2'd2;

  logic [1:0]       state, state_next;
  logic             kind_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    raddr, raddr_next;
  logic             rd_pend, rd_pend_next;
  logic [AW-1:0]    rd_addr, rd_addr_next;
  arpc_res_t        res_q, res_next;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  arpc_entry_t      mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [EW-1:0]    mem_rdata;
  arpc_entry_t      rd_entry;
  logic             match;
  logic             scan_done;
  logic             accept;
  logic             drop_legal;

  arpc_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_entry  = arpc_entry_t'(mem_rdata);
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  // Occupied slots are exactly those below the fill count.
  assign match     = rd_pend && (rd_entry.ip == ip_q);
  assign scan_done = !rd_pend && (raddr == count);
  assign res_valid = (state == ST_RESP);
  assign res       = res_q;
  // A dropped insert is only possible for an insert on a full table.
  assign drop_legal = (kind_q == KIND_INSERT) && (count == CW'(ENTRIES));

  always_comb begin
    state_next   = state;
    count_next   = count;
    raddr_next   = raddr;
    rd_pend_next = rd_pend;
    rd_addr_next = rd_addr;
    res_next     = res_q;
    mem_we       = 1'b0;
    mem_waddr    = rd_addr;
    mem_wdata    = '{ip: ip_q, mac: mac_q};
    mem_re       = 1'b0;
    mem_raddr    = raddr[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next   = ST_SEARCH;
          raddr_next   = '0;
          rd_pend_next = 1'b0;
        end
      end
      ST_SEARCH: begin
        priority if (match) begin
          res_next.hit        = 1'b1;
          res_next.found_mac  = (kind_q == KIND_LOOKUP) ? rd_entry.mac : '0;
          res_next.table_full = 1'b0;
          mem_we              = (kind_q == KIND_INSERT);
          state_next          = ST_RESP;
        end else if (scan_done) begin
          res_next = '0;
          if (kind_q == KIND_INSERT) begin
            if (count < CW'(ENTRIES)) begin
              mem_we     = 1'b1;
              mem_waddr  = count[AW-1:0];
              count_next = count + CW'(1);
            end else begin
              res_next.table_full = 1'b1;
            end
          end
          state_next = ST_RESP;
        end else begin
          rd_pend_next = (raddr < count);
          if (raddr < count) begin
            mem_re       = 1'b1;
            rd_addr_next = raddr[AW-1:0];
            raddr_next   = raddr + CW'(1);
          end
        end
      end
      ST_RESP: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    raddr   <= raddr_next;
    rd_addr <= rd_addr_next;
    res_q   <= res_next;
    if (accept) begin
      kind_q <= req.kind;
      ip_q   <= req.ip_addr;
      mac_q  <= req.mac_addr;
    end
  end

  `ARPC_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(ENTRIES))
  `ARPC_ASSERT_IMP(a_write_in_search, clk, rst, mem_we, state == ST_SEARCH)
  `ARPC_ASSERT_IMP(a_full_only_insert, clk, rst, res_valid && res_q.table_full, drop_legal)

endmodule

// ===== rtl/arp_cache_table.sv =====
// Top level of the ARP cache table: IPv4 to MAC lookup and insert with a result register.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    kind, ip_addr[31:0], mac_addr[47:0]
//   rsp      out  valid/ready    hit, found_mac[47:0], table_full
//
// An item scans the occupied slots one per cycle and stops at a matching IP. Its result
// is registered in the sequencer and then in the output register before it reaches rsp.
// req is ready again in the cycle in which the result appears. Reset clears the fill
// count and the control state but not the slots, because slots fill in order and are
// never freed. While rsp stalls, the next item is still accepted and searched, and its
// finished result then waits in the sequencer.
`include "arp_cache_table_macros.svh"

module arp_cache_table import arpc_pkg::*; #(
  parameter int ENTRIES = ARPC_ENTRIES
) (
  input  logic     clk,
  input  logic     rst,
  arpc_req_if.sink req,
  arpc_rsp_if.source rsp
);

  logic      res_valid;
  logic      res_ready;
  arpc_res_t res;
  logic      out_valid;
  arpc_res_t out_data;

  arpc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register takes a new result when empty or when its item is taken.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_data.hit;
  assign rsp.found_mac  = out_data.found_mac;
  assign rsp.table_full = out_data.table_full;

  `ARPC_ASSERT_NXT(a_res_loaded, clk, rst, res_valid && res_ready, out_valid)
  `ARPC_ASSERT_NXT(a_out_held, clk, rst, out_valid && !rsp.ready, out_valid)
  `ARPC_ASSERT_IMP(a_hit_not_full, clk, rst, out_valid, !(out_data.hit && out_data.table_full))

endmodule
